// ===== sv/cmwc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmwc_pkg
// shared types, constants and codes of the column melt wipe compositor
// ----------------------------------------------------------------------------
package cmwc_pkg;

  localparam int MaxColumnsDef = 1024;
  localparam int QueueDepth    = 2;

  localparam int OffW  = 13;
  localparam int ColW  = 10;
  localparam int RowW  = 11;
  localparam int CfgW  = 11;
  localparam int StepW = 7;
  localparam int TickW = 4;
  localparam int CfgIdxW = 1;

  localparam logic [CfgW-1:0] ScreenWidthRst  = 11'd320;
  localparam logic [CfgW-1:0] ScreenHeightRst = 11'd200;

  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 1'd1;

  // height / 25 as (height * 1311) >> 15, exact for 11-bit heights
  localparam logic [CfgW-1:0] Div25Mul   = 11'd1311;
  localparam int              Div25Shift = 15;

  localparam logic signed [OffW-1:0] FastLimit = 13'sd16;
  localparam logic signed [OffW-1:0] LoadFloor = -13'sd16;
  localparam logic signed [OffW-1:0] LoadMin   = -13'sd15;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [ColW-1:0]  column;
    logic [RowW-1:0]  row;
    logic [7:0]       random_byte;
    logic [TickW-1:0] tick_count;
  } in_item_t;

  typedef struct packed {
    logic                   done_res;
    logic                   source_is_end;
    logic [RowW-1:0]        source_row;
    logic signed [11:0]     column_offset;
  } out_item_t;

  typedef struct packed {
    op_e                    op;
    logic [ColW-1:0]        col;
    logic                   in_range;
    logic [RowW-1:0]        row;
    logic signed [OffW-1:0] value;
    logic [TickW-1:0]       ticks;
  } cmd_t;

endpackage

// ===== sv/cmwc_if.sv =====
// ----------------------------------------------------------------------------
// cmwc stream interfaces
// valid/ready channels for input and result words
// ----------------------------------------------------------------------------
interface cmwc_in_if;
  import cmwc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cmwc_out_if;
  import cmwc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/column_melt_wipe_compositor_core.sv =====
// ----------------------------------------------------------------------------
// column_melt_wipe_compositor_core
// melt wipe column offsets: load, advance sweep and pixel source query
// ----------------------------------------------------------------------------
// the back pops a command only when idle with the result register free and takes no
// new one before the last has answered; load writes the offset memory and the result
// together; query and unused opcode read the offset memory into a register, then answer;
// advance does a read-modify-write of each column in use per tick, then reads and answers
// reset: queue empty, result invalid, previous offset 0, width 320, height 200
// offset memory is not cleared; columns must be loaded before use
module column_melt_wipe_compositor_core
  import cmwc_pkg::*;
#(
  parameter int MAX_COLUMNS = MaxColumnsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  cmwc_in_if.sink            in_i,
  cmwc_out_if.source         out_o
);

  logic [CfgW-1:0] width_q, height_q;
  logic            full, empty, push, pop;
  cmd_t            cmd_in, cmd_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ScreenWidthRst;
      height_q <= ScreenHeightRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgScreenWidth) begin
        width_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == CfgScreenHeight) begin
        height_q <= cfg_wdata_i;
      end
    end
  end

  cmwc_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  cmwc_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (cmd_out)
  );

  cmwc_back #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .width_i  (width_q),
    .height_i (height_q),
    .empty_i  (empty),
    .cmd_i    (cmd_out),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

// ===== sv/cmwc_front.sv =====
// ----------------------------------------------------------------------------
// cmwc_front
// accepts input words, decodes them and works out load offsets
// ----------------------------------------------------------------------------
module cmwc_front
  import cmwc_pkg::*;
#(
  parameter int MAX_COLUMNS = MaxColumnsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cmwc_in_if.sink    in_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic signed [OffW-1:0] prev_q, prev_d;
  logic signed [OffW-1:0] load_v, step_v;
  logic [3:0]             s1;
  logic [2:0]             s2;
  logic [1:0]             m3;

  // random_byte mod 3 through base-4 digit sums
  always_comb begin
    s1 = 4'(in_i.data.random_byte[1:0]) + 4'(in_i.data.random_byte[3:2])
       + 4'(in_i.data.random_byte[5:4]) + 4'(in_i.data.random_byte[7:6]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
    if (s2 >= 3'd3) begin
      s2 = s2 - 3'd3;
    end
    if (s2 >= 3'd3) begin
      s2 = s2 - 3'd3;
    end
    m3 = s2[1:0];
  end

  always_comb begin
    step_v = prev_q + signed'({11'd0, m3}) - 13'sd1;
    if (in_i.data.column == '0) begin
      load_v = -signed'({9'd0, in_i.data.random_byte[3:0]});
    end else if (step_v > 13'sd0) begin
      load_v = '0;
    end else if (step_v == LoadFloor) begin
      load_v = LoadMin;
    end else begin
      load_v = step_v;
    end
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    cmd_o.op       = op_e'(in_i.data.opcode);
    cmd_o.col      = in_i.data.column;
    cmd_o.in_range = 32'(in_i.data.column) < MAX_COLUMNS;
    cmd_o.row      = in_i.data.row;
    cmd_o.value    = load_v;
    cmd_o.ticks    = in_i.data.tick_count;
  end

  always_comb begin
    prev_d = prev_q;
    if (push_o && (op_e'(in_i.data.opcode) == OP_LOAD)) begin
      prev_d = load_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

// ===== sv/cmwc_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// cmwc_cmd_fifo
// short command queue between decode and execution
// ----------------------------------------------------------------------------
module cmwc_cmd_fifo
  import cmwc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign cmd_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== sv/cmwc_back.sv =====
// ----------------------------------------------------------------------------
// cmwc_back
// executes commands against the column offset memory, holds the result word
// ----------------------------------------------------------------------------
module cmwc_back
  import cmwc_pkg::*;
#(
  parameter int MAX_COLUMNS = MaxColumnsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CfgW-1:0] width_i,
  input  logic [CfgW-1:0] height_i,
  input  logic            empty_i,
  input  cmd_t            cmd_i,
  output logic            pop_o,
  cmwc_out_if.source      out_o
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int UW = CW + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MRD  = 5'b00010,
    S_MWR  = 5'b00100,
    S_READ = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  cmd_t                   cur_q, cur_d;
  logic [CW-1:0]          col_q, col_d;
  logic [TickW-1:0]       tick_q, tick_d;
  logic                   moved_q, moved_d;
  logic                   ovalid_q, ovalid_d;
  out_item_t              odata_q, odata_d;
  logic [StepW-1:0]       step_q;
  logic [21:0]            step_prod;

  logic signed [OffW-1:0] mem [MAX_COLUMNS];
  logic signed [OffW-1:0] rdata_q;
  logic                   rd_en, we;
  logic [CW-1:0]          rd_addr, wr_addr;
  logic signed [OffW-1:0] wr_data;

  logic [UW-1:0]          used;
  logic                   last_col, out_free, start;
  logic signed [OffW-1:0] y, hs, dy, sum, ny, rowq, yq;
  logic                   mv;

  assign step_prod = 22'(height_i) * 22'(Div25Mul);

  always_ff @(posedge clk_i) begin
    step_q <= step_prod[Div25Shift +: StepW];
  end

  assign used = (32'(width_i) >= MAX_COLUMNS) ? UW'(MAX_COLUMNS) : UW'(width_i);
  assign last_col = (UW'(col_q) + 1'b1) >= used;
  assign out_free = !ovalid_q || out_o.ready;
  assign start    = (state_q == S_IDLE) && !empty_i && out_free;
  assign pop_o    = start;

  // melt step for the column just read
  always_comb begin
    y   = rdata_q;
    hs  = signed'({2'b00, height_i});
    dy  = (y < FastLimit) ? y + 13'sd1 : signed'({6'd0, step_q});
    sum = y + dy;
    ny  = y;
    mv  = 1'b0;
    if (y < 13'sd0) begin
      ny = y + 13'sd1;
      mv = 1'b1;
    end else if (y < hs) begin
      ny = (sum >= hs) ? hs : sum;
      mv = 1'b1;
    end
  end

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    col_d    = col_q;
    tick_d   = tick_q;
    moved_d  = moved_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    rd_en    = 1'b0;
    rd_addr  = CW'(cur_q.col);
    we       = 1'b0;
    wr_addr  = col_q;
    wr_data  = ny;
    rowq     = signed'({2'b00, cur_q.row});
    yq       = cur_q.in_range ? rdata_q : '0;

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cur_d   = cmd_i;
          rd_addr = CW'(cmd_i.col);
          unique case (cmd_i.op)
            OP_LOAD: begin
              we       = cmd_i.in_range;
              wr_addr  = CW'(cmd_i.col);
              wr_data  = cmd_i.value;
              ovalid_d = 1'b1;
              odata_d  = '0;
              odata_d.column_offset = cmd_i.in_range ? cmd_i.value[11:0] : '0;
            end
            OP_ADVANCE: begin
              moved_d = 1'b0;
              col_d   = '0;
              tick_d  = cmd_i.ticks;
              if ((cmd_i.ticks == '0) || (used == '0)) begin
                rd_en   = 1'b1;
                state_d = S_RESP;
              end else begin
                state_d = S_MRD;
              end
            end
            default: begin
              rd_en   = 1'b1;
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_MRD: begin
        rd_en   = 1'b1;
        rd_addr = col_q;
        state_d = S_MWR;
      end
      S_MWR: begin
        we      = 1'b1;
        moved_d = moved_q || mv;
        state_d = S_MRD;
        if (!last_col) begin
          col_d = col_q + 1'b1;
        end else if (tick_q == TickW'(1)) begin
          state_d = S_READ;
        end else begin
          col_d  = '0;
          tick_d = tick_q - 1'b1;
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        ovalid_d = 1'b1;
        odata_d  = '0;
        odata_d.column_offset = yq[11:0];
        unique case (cur_q.op)
          OP_ADVANCE: begin
            odata_d.done_res = !moved_q;
          end
          OP_QUERY: begin
            if (yq < 13'sd0) begin
              odata_d.source_row = cur_q.row;
            end else if (rowq < yq) begin
              odata_d.source_is_end = 1'b1;
              odata_d.source_row    = cur_q.row;
            end else begin
              odata_d.source_row = RowW'(rowq - yq);
            end
          end
          default: begin
          end
        endcase
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      moved_q  <= 1'b0;
      tick_q   <= '0;
      col_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      moved_q  <= moved_d;
      tick_q   <= tick_d;
      col_q    <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    odata_q <= odata_d;
  end

  assign out_o.valid = ovalid_q;
  assign out_o.data  = odata_q;

endmodule

// ===== sim/column_melt_wipe_compositor_checker.sv =====
// ----------------------------------------------------------------------------
// column_melt_wipe_compositor_checker
// watches the input and result channels and the register write port, keeps
// its own copy of the column offsets and registers, works out the result
// word of every accepted input word and compares it field by field with the
// result words the core hands out, oldest first
// ----------------------------------------------------------------------------
module column_melt_wipe_compositor_checker
  import cmwc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  cmwc_in_if                 in_mon,
  cmwc_out_if                out_mon,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableDepth   = MaxColumnsDef;
  localparam int WidthAtReset = 320;
  localparam int HeightAtRst  = 200;
  localparam int SlowFrom     = 16;
  localparam int StepDivisor  = 25;
  localparam int SeedSpan     = 16;
  localparam int StepSpan     = 3;
  localparam int LoadTooLow   = -16;
  localparam int LoadLowest   = -15;
  localparam int ReportLimit  = 10;

  logic signed [OffW-1:0] melt_offset [TableDepth];
  logic signed [OffW-1:0] last_load;
  int                     width_reg;
  int                     height_reg;
  out_item_t              due_results [$];
  out_item_t              want;
  out_item_t              got;
  int                     mismatches;

  function automatic bit melt_column(int col);
    int y;
    int dy;
    y = melt_offset[col];
    if (y < 0) begin
      melt_offset[col] = OffW'(y + 1);
      return 1'b1;
    end
    if (y < height_reg) begin
      dy = (y < SlowFrom) ? (y + 1) : (height_reg / StepDivisor);
      if (y + dy >= height_reg) dy = height_reg - y;
      melt_offset[col] = OffW'(y + dy);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t wipe_result(in_item_t w);
    out_item_t r;
    int        v;
    int        y;
    int        used;
    int        row_n;
    bit        moved;
    r = '0;
    case (op_e'(w.opcode))
      OP_LOAD: begin
        if (w.column == '0) begin
          v = -int'(w.random_byte % SeedSpan);
        end else begin
          v = int'(last_load) + int'(w.random_byte % StepSpan) - 1;
          if (v > 0) v = 0;
          else if (v == LoadTooLow) v = LoadLowest;
        end
        last_load = OffW'(v);
        melt_offset[w.column] = OffW'(v);
      end
      OP_ADVANCE: begin
        used  = (width_reg > TableDepth) ? TableDepth : width_reg;
        moved = 1'b0;
        for (int t = 0; t < int'(w.tick_count); t++) begin
          for (int i = 0; i < used; i++) begin
            if (melt_column(i)) moved = 1'b1;
          end
        end
        r.done_res = !moved;
      end
      OP_QUERY: begin
        y     = melt_offset[w.column];
        row_n = int'(w.row);
        if (y < 0) begin
          r.source_row = w.row;
        end else if (row_n < y) begin
          r.source_is_end = 1'b1;
          r.source_row    = w.row;
        end else begin
          r.source_row = RowW'(row_n - y);
        end
      end
      default: ;
    endcase
    r.column_offset = 12'(melt_offset[w.column]);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_results.delete();
      last_load    = '0;
      width_reg    = WidthAtReset;
      height_reg   = HeightAtRst;
      mismatches   = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("%t unexpected result word: done=%0d end=%0d row=%0d offset=%0d",
                     $realtime, got.done_res, got.source_is_end, got.source_row,
                     got.column_offset);
        end else begin
          want = due_results.pop_front();
          if (want.done_res !== got.done_res || want.source_is_end !== got.source_is_end ||
              want.source_row !== got.source_row ||
              want.column_offset !== got.column_offset) begin
            mismatches++;
            if (mismatches <= ReportLimit)
              $display("%t result mismatch: want done=%0d end=%0d row=%0d offset=%0d, got done=%0d end=%0d row=%0d offset=%0d",
                       $realtime, want.done_res, want.source_is_end, want.source_row,
                       want.column_offset, got.done_res, got.source_is_end,
                       got.source_row, got.column_offset);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) due_results.push_back(wipe_result(in_mon.data));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgScreenWidth:  width_reg = int'(cfg_wdata_i);
          CfgScreenHeight: height_reg = int'(cfg_wdata_i);
          default: ;
        endcase
      end
      pending_o    <= due_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== sim/column_melt_wipe_compositor_core_tb.sv =====
// ----------------------------------------------------------------------------
// column_melt_wipe_compositor_core_tb
// drives load, advance, query and unused words into the core under a series
// of width and height settings, with random gaps on both channels and one
// or more long result stalls; the checker beside the core predicts and
// compares every result word
// ----------------------------------------------------------------------------
module column_melt_wipe_compositor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cmwc_pkg::*;

  localparam int TableDepth  = MaxColumnsDef;
  localparam int MaxRow      = 2047;
  localparam int BurstLen    = 40;
  localparam int HoldCycles  = 150;
  localparam int PhaseWords  = 8;
  localparam int DrainCycles = 100;
  localparam int NumPhases   = 13;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;
  int                 fail_count;
  int                 pending;

  cmwc_in_if  in_ch ();
  cmwc_out_if out_ch ();

  column_melt_wipe_compositor_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  column_melt_wipe_compositor_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  bit written_col [TableDepth];
  int written_list [$];
  int loaded_prefix = 0;
  int load_next = 0;
  int cur_height = 200;
  bit steady = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int rand_row();
    int top;
    top = (cur_height + 20 > MaxRow) ? MaxRow : cur_height + 20;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, MaxRow);
    return $urandom_range(0, top);
  endfunction

  function automatic int any_written_col();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  function automatic in_item_t pack_word(op_e op, int col, int row, int rnd, int ticks);
    in_item_t w;
    w.opcode      = op;
    w.column      = ColW'(col);
    w.row         = RowW'(row);
    w.random_byte = 8'(rnd);
    w.tick_count  = TickW'(ticks);
    return w;
  endfunction

  task automatic send_word(input in_item_t w);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    if (w.opcode == OP_LOAD) begin
      if (!written_col[w.column]) begin
        written_col[w.column] = 1'b1;
        written_list.push_back(int'(w.column));
      end
      while (loaded_prefix < TableDepth && written_col[loaded_prefix]) loaded_prefix++;
    end
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input int value);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CfgW'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // queries sent back to back while the result side holds off
  task automatic flood_queries();
    bit keep;
    keep   = steady;
    steady = 1'b1;
    hold_req++;
    repeat (BurstLen)
      send_word(pack_word(OP_QUERY, any_written_col(), rand_row(), $urandom_range(0, 255),
                          $urandom_range(0, 15)));
    steady = keep;
  endtask

  task automatic random_word(input int used, output int n);
    int pick;
    int span;
    if ($urandom_range(0, 15) == 0) steady = !steady;
    pick = $urandom_range(0, 99);
    n    = 1;
    if (pick < 30) begin
      // in-order load run upward from the next load column, wrapping back to column 0
      n    = $urandom_range(1, 16);
      span = (used > 0) ? used : 16;
      repeat (n) begin
        send_word(pack_word(OP_LOAD, load_next, rand_row(), $urandom_range(0, 255),
                            $urandom_range(0, 15)));
        load_next++;
        if (load_next >= span || $urandom_range(0, 31) == 0) load_next = 0;
      end
    end else if (pick < 70) begin
      send_word(pack_word(OP_QUERY, any_written_col(), rand_row(), $urandom_range(0, 255),
                          $urandom_range(0, 15)));
    end else if (pick < 76) begin
      send_word(pack_word(OP_LOAD, $urandom_range(0, TableDepth - 1), rand_row(),
                          $urandom_range(0, 255), $urandom_range(0, 15)));
    end else if (pick < 81) begin
      send_word(pack_word(OP_NOP, any_written_col(), rand_row(), $urandom_range(0, 255),
                          $urandom_range(0, 15)));
    end else if (pick < 83) begin
      flood_queries();
      n = BurstLen;
    end else if (used <= 64) begin
      send_word(pack_word(OP_ADVANCE, any_written_col(), rand_row(), $urandom_range(0, 255),
                          $urandom_range(0, 15)));
    end else if ($urandom_range(0, 4) == 0) begin
      send_word(pack_word(OP_ADVANCE, any_written_col(), rand_row(), $urandom_range(0, 255),
                          $urandom_range(0, 2)));
    end else begin
      send_word(pack_word(OP_QUERY, any_written_col(), rand_row(), $urandom_range(0, 255),
                          $urandom_range(0, 15)));
    end
  endtask

  // result side: random gaps, calm stretches and requested long hold-offs
  initial begin
    int gap;
    int calm_left;
    out_ch.ready = 1'b0;
    calm_left    = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen++;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        if (calm_left > 0) begin
          calm_left--;
          gap = 0;
        end else begin
          gap = idle_len();
          if ($urandom_range(0, 24) == 0) calm_left = $urandom_range(20, 200);
        end
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int phase_w [10];
    int phase_h [10];
    int w;
    int h;
    int used;
    int made;
    int n;
    phase_w = '{0, 1, 16, 7, 2047, 40, 64, 1024, 3, 24};
    phase_h = '{24, 2047, 200, 0, 25, 100, 2046, 2047, 25, 60};
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    cfg_write(CfgScreenWidth, 4);
    cfg_write(CfgScreenHeight, 25);
    cur_height = 25;
    send_word(pack_word(OP_LOAD, 0, 0, 255, 0));
    send_word(pack_word(OP_LOAD, 1, MaxRow, 0, 15));
    send_word(pack_word(OP_LOAD, 2, 0, 2, 0));
    send_word(pack_word(OP_LOAD, 3, 0, 240, 0));
    send_word(pack_word(OP_LOAD, TableDepth - 1, 0, 1, 0));
    send_word(pack_word(OP_LOAD, 0, 0, 16, 0));
    send_word(pack_word(OP_LOAD, 5, 0, 2, 0));
    send_word(pack_word(OP_QUERY, 1, MaxRow, 0, 0));
    send_word(pack_word(OP_QUERY, TableDepth - 1, 0, 255, 15));
    send_word(pack_word(OP_NOP, 3, MaxRow, 255, 15));
    send_word(pack_word(OP_ADVANCE, 0, 0, 0, 0));
    send_word(pack_word(OP_ADVANCE, 2, 0, 0, 15));
    send_word(pack_word(OP_ADVANCE, 3, 0, 0, 15));
    send_word(pack_word(OP_ADVANCE, 1, 0, 0, 15));
    send_word(pack_word(OP_QUERY, 0, 24, 0, 0));
    send_word(pack_word(OP_QUERY, 0, 25, 0, 0));
    send_word(pack_word(OP_QUERY, 0, MaxRow, 0, 0));
    send_word(pack_word(OP_QUERY, 5, 0, 0, 0));
    flood_queries();

    for (int p = 0; p < NumPhases; p++) begin
      if (p < 10) begin
        w = phase_w[p];
        h = phase_h[p];
      end else begin
        w = $urandom_range(1, 64);
        h = $urandom_range(25, 2047);
      end
      cfg_write(CfgScreenWidth, w);
      cfg_write(CfgScreenHeight, h);
      cur_height = h;
      used       = (w > TableDepth) ? TableDepth : w;
      load_next  = 0;
      if (loaded_prefix < used) begin
        for (int c = 0; c < used; c++)
          send_word(pack_word(OP_LOAD, c, rand_row(), $urandom_range(0, 255),
                              $urandom_range(0, 15)));
      end
      if (used == TableDepth)
        send_word(pack_word(OP_ADVANCE, any_written_col(), rand_row(), 0, 15));
      made = 0;
      while (made < PhaseWords) begin
        random_word(used, n);
        made += n;
      end
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
